// ===== hw/rtl/betrig_pkg.sv =====
package betrig_pkg;

	// fixed field widths
	localparam int ENERGY_W   = 55;
	localparam int BLEN_W     = 9;
	localparam int CNT_W      = 8;
	localparam int HOLD_W     = 16;
	localparam int CAPLEN_W   = 15;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = ENERGY_W;

	typedef logic [ENERGY_W-1:0] energy_t;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_BLOCKS   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LENGTH   = 4'd3;

	// register reset values
	localparam logic [BLEN_W-1:0]   BLOCK_LENGTH_RST     = 9'd48;
	localparam energy_t             ENERGY_THRESHOLD_RST = 55'd303992974847508;
	localparam logic [HOLD_W-1:0]   HOLDOFF_BLOCKS_RST   = 16'd1000;
	localparam logic [CAPLEN_W-1:0] CAPTURE_LENGTH_RST   = 15'd14400;

	// longest block
	localparam logic [BLEN_W-1:0] BLEN_MAX = 9'd256;

	// elapsed block counter ceiling
	localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;

endpackage

// ===== hw/rtl/betrig_energy.sv =====
module betrig_energy
	import betrig_pkg::*;
#(
	parameter int SQ_W = 48
) (
	input  energy_t          sum,
	input  logic [SQ_W-1:0]  sq,
	input  energy_t          thr,
	output energy_t          sum_next,
	output logic             over
);

	localparam int EXT_W = ((SQ_W > ENERGY_W) ? SQ_W : ENERGY_W) + 1;

	logic [EXT_W-1:0] ext;
	logic             sat;

	// saturating accumulate, then strict compare against threshold
	assign ext      = {{(EXT_W-ENERGY_W){1'b0}}, sum} + {{(EXT_W-SQ_W){1'b0}}, sq};
	assign sat      = |ext[EXT_W-1:ENERGY_W];
	assign sum_next = sat ? {ENERGY_W{1'b1}} : ext[ENERGY_W-1:0];
	assign over     = (sum_next > thr);

endmodule

// ===== hw/rtl/block_energy_trigger_with_holdoff_core.sv =====
// block energy level trigger with holdoff
//
// input channel (in_valid/in_ready): one word per item, kind 0 carries an
// audio sample, kind 1 reports that analysis has finished and clears the
// pending flag. output channel (out_valid/out_ready): exactly one result word
// per input word, in order: capture write index, block end, trigger, pending.
// config channel (cfg_valid/cfg_ready): always ready, cfg_index selects
// block_length (0), energy_threshold (1), holdoff_blocks (2) or
// capture_length (3); other indexes are ignored. write only while idle.
//
// an accepted word is squared into the squarer register, whose output feeds the
// state update into the result register.
// throughput: one word per cycle while out_ready stays high, set by the state update loop
// (saturating energy add plus threshold compare), which is combinational.
// a stalled receiver holds the result register; the squarer stage keeps
// taking words until it is full, so in_ready drops one word later.
// reset clears all counters, energy, pending flag and both pipeline valids,
// and loads the register defaults.
module block_energy_trigger_with_holdoff_core
	import betrig_pkg::*;
#(
	parameter int MAX_CAPTURE = 16384,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [$clog2(MAX_CAPTURE)-1:0]  write_index,
	output logic                            block_end,
	output logic                            trigger,
	output logic                            pending,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [CFG_IDX_W-1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0]           cfg_data
);

	localparam int IDX_W = $clog2(MAX_CAPTURE);
	localparam int SQ_W  = 2 * SAMPLE_BITS;
	localparam int CMP_W = (IDX_W + 1 > CAPLEN_W) ? IDX_W + 1 : CAPLEN_W;

	// config registers
	logic [BLEN_W-1:0]   blen_q;
	energy_t             thr_q;
	logic [HOLD_W-1:0]   hold_q;
	logic [CAPLEN_W-1:0] clen_q;

	// block state
	logic [IDX_W-1:0]    pos_q;
	logic [CNT_W-1:0]    cnt_q;
	energy_t             sum_q;
	logic [HOLD_W-1:0]   bst_q;
	logic                pend_q;

	// stage 1: squared sample
	logic                valid_s1;
	logic                kind_s1;
	logic [SQ_W-1:0]     sq_s1;

	// result register
	logic                out_valid_q;
	logic [IDX_W-1:0]    write_index_q;
	logic                block_end_q;
	logic                trigger_q;
	logic                pending_q;

	logic                    take_in;
	logic                    adv;
	logic [SAMPLE_BITS-1:0]  mag;
	logic [SQ_W-1:0]         sq_c;
	energy_t                 sum_next;
	logic                    over;
	logic [BLEN_W-1:0]       blen_eff;
	logic [BLEN_W-1:0]       cnt_inc;
	logic                    blk_end;
	logic [CMP_W-1:0]        clen_ext;
	logic [CMP_W-1:0]        clen_eff;
	logic [CMP_W-1:0]        pos_inc;
	logic [IDX_W-1:0]        pos_next;
	logic [HOLD_W-1:0]       elapsed;
	logic                    trig;

	// handshakes: stage 2 moves when the result register is free or drained
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign take_in   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// magnitude then square; the most negative code maps to 2^(n-1)
	assign mag  = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
	assign sq_c = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};

	betrig_energy #(
		.SQ_W (SQ_W)
	) u_energy (
		.sum      (sum_q),
		.sq       (sq_s1),
		.thr      (thr_q),
		.sum_next (sum_next),
		.over     (over)
	);

	// block length clamped to 1..256
	always_comb begin
		if (blen_q == '0) begin
			blen_eff = BLEN_W'(1);
		end else if (blen_q > BLEN_MAX) begin
			blen_eff = BLEN_MAX;
		end else begin
			blen_eff = blen_q;
		end
	end

	assign cnt_inc = {1'b0, cnt_q} + BLEN_W'(1);
	assign blk_end = (cnt_inc >= blen_eff);

	// capture length clamped to 1..MAX_CAPTURE
	assign clen_ext = CMP_W'(clen_q);
	always_comb begin
		if (clen_q == '0) begin
			clen_eff = CMP_W'(1);
		end else if (clen_ext > CMP_W'(MAX_CAPTURE)) begin
			clen_eff = CMP_W'(MAX_CAPTURE);
		end else begin
			clen_eff = clen_ext;
		end
	end

	// a position left beyond a shortened length wraps to zero too
	assign pos_inc  = CMP_W'(pos_q) + CMP_W'(1);
	assign pos_next = (pos_inc >= clen_eff) ? '0 : pos_inc[IDX_W-1:0];

	// elapsed block count saturates, so the largest holdoff never expires
	assign elapsed = (bst_q == HOLD_MAX) ? bst_q : bst_q + HOLD_W'(1);
	assign trig    = blk_end && !pend_q && (elapsed > hold_q) && over;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q <= BLOCK_LENGTH_RST;
			thr_q  <= ENERGY_THRESHOLD_RST;
			hold_q <= HOLDOFF_BLOCKS_RST;
			clen_q <= CAPTURE_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BLOCK_LENGTH:     blen_q <= cfg_data[BLEN_W-1:0];
				REG_ENERGY_THRESHOLD: thr_q  <= cfg_data[ENERGY_W-1:0];
				REG_HOLDOFF_BLOCKS:   hold_q <= cfg_data[HOLD_W-1:0];
				REG_CAPTURE_LENGTH:   clen_q <= cfg_data[CAPLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline valids and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			bst_q       <= '0;
			pend_q      <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end

			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (adv) begin
				if (kind_s1) begin
					// analysis finished: only the flag changes
					pend_q <= 1'b0;
				end else begin
					pos_q <= pos_next;
					if (blk_end) begin
						cnt_q  <= '0;
						sum_q  <= '0;
						bst_q  <= trig ? '0 : elapsed;
						pend_q <= pend_q || trig;
					end else begin
						cnt_q <= cnt_inc[CNT_W-1:0];
						sum_q <= sum_next;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_s1 <= kind;
			sq_s1   <= sq_c;
		end
		if (adv) begin
			write_index_q <= pos_q;
			if (kind_s1) begin
				block_end_q <= 1'b0;
				trigger_q   <= 1'b0;
				pending_q   <= 1'b0;
			end else begin
				block_end_q <= blk_end;
				trigger_q   <= trig;
				pending_q   <= pend_q || trig;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign write_index = write_index_q;
	assign block_end   = block_end_q;
	assign trigger     = trigger_q;
	assign pending     = pending_q;

	// a trigger only comes with a block end and leaves the request pending
	a_trig_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && trigger_q |-> block_end_q && pending_q)
		else $error("trigger without block end or pending");

	// the pending flag only rises on a state update that triggered
	a_pend_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_q) |-> $past(adv) && $past(trig) && !$past(kind_s1))
		else $error("pending rose without a trigger");

	// a stalled squarer stage keeps its word
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(sq_s1) && $stable(kind_s1))
		else $error("stage 1 word lost while stalled");

	// the holdoff counter restarts exactly on a trigger
	a_holdoff_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !kind_s1 && trig |=> bst_q == '0)
		else $error("holdoff count not restarted");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import betrig_pkg::*;

	// block geometry as built with default parameters
	localparam int SAMPLE_W = 24;
	localparam int IDX_W    = 14;
	localparam int MAX_CAP  = 16384;

	// word kinds on the input channel
	localparam logic KIND_AUDIO = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	// an index outside the register map, the block must ignore it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		logic                       kind;
		logic signed [SAMPLE_W-1:0] sample;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] write_index;
		logic             block_end;
		logic             trigger;
		logic             pending;
	} result_t;

	// dut ports
	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic                       kind      = KIND_AUDIO;
	logic signed [SAMPLE_W-1:0] sample    = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [IDX_W-1:0]           write_index;
	logic                       block_end;
	logic                       trigger;
	logic                       pending;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data  = '0;

	// words waiting to be driven and results waiting to be seen
	in_word_t word_backlog[$];
	result_t  expected_results[$];
	in_word_t next_word;
	result_t  predicted;
	result_t  front_result;

	// idle percentages of the two sides, changed between phases
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int mismatch_count  = 0;
	int words_sent      = 0;
	int results_checked = 0;
	int block_ends_seen = 0;
	int triggers_seen   = 0;

	// shadow copy of the register file
	logic [BLEN_W-1:0]   shadow_blen;
	energy_t             shadow_thresh;
	logic [HOLD_W-1:0]   shadow_hold;
	logic [CAPLEN_W-1:0] shadow_caplen;

	// shadow copy of the trigger state
	logic [IDX_W-1:0]  cap_pos;
	logic [CNT_W-1:0]  blk_cnt;
	energy_t           energy_acc;
	logic [HOLD_W-1:0] blocks_elapsed;
	logic              pend_flag;

	block_energy_trigger_with_holdoff_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.write_index(write_index),
		.block_end  (block_end),
		.trigger    (trigger),
		.pending    (pending),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #10 clk = ~clk;

	// next state of the trigger logic for one accepted word, and its result
	task automatic energy_trigger_step(input logic k, input logic signed [SAMPLE_W-1:0] s,
			output result_t r);
		int unsigned            clen;
		int unsigned            blen;
		int unsigned            elapsed;
		logic [SAMPLE_W-1:0]    mag;
		logic [2*SAMPLE_W-1:0]  sq;
		logic [ENERGY_W:0]      sum;
		r = '0;
		if (k == KIND_DONE) begin
			// analysis finished: only the pending flag changes
			pend_flag = 1'b0;
			r.write_index = cap_pos;
			return;
		end
		// capture slot, wrap at the clamped capture length
		clen = 32'(shadow_caplen);
		if (clen == 0) clen = 1;
		if (clen > MAX_CAP) clen = MAX_CAP;
		r.write_index = cap_pos;
		cap_pos = (int'(cap_pos) + 1 >= clen) ? '0 : cap_pos + 1'b1;
		// magnitude squared, the most negative sample gives 2^23 unsigned
		mag = s[SAMPLE_W-1] ? -s : s;
		sq  = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);
		sum = {1'b0, energy_acc} + (ENERGY_W+1)'(sq);
		energy_acc = sum[ENERGY_W] ? {ENERGY_W{1'b1}} : sum[ENERGY_W-1:0];
		// block boundary with clamped block length
		blen = 32'(shadow_blen);
		if (blen == 0) blen = 1;
		if (blen > 256) blen = 256;
		if (int'(blk_cnt) + 1 >= blen) begin
			r.block_end = 1'b1;
			blk_cnt = '0;
			elapsed = int'(blocks_elapsed) + 1;
			if (elapsed > 65535) elapsed = 65535;
			if (!pend_flag && elapsed > shadow_hold && energy_acc > shadow_thresh) begin
				r.trigger = 1'b1;
				pend_flag = 1'b1;
				elapsed = 0;
			end
			blocks_elapsed = HOLD_W'(elapsed);
			energy_acc = '0;
		end else begin
			blk_cnt = blk_cnt + 1'b1;
		end
		r.pending = pend_flag;
	endtask

	task automatic note_mismatch(input string what, input logic [IDX_W-1:0] exp_v,
			input logic [IDX_W-1:0] act_v);
		mismatch_count++;
		if (mismatch_count <= SHOW_LIMIT)
			$display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
	endtask

	// driver: holds the word until accepted, predicts at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind     <= KIND_AUDIO;
			sample   <= '0;
		end else begin
			if (in_valid && in_ready) begin
				energy_trigger_step(kind, sample, predicted);
				expected_results.push_back(predicted);
				words_sent++;
			end
			if (!in_valid || in_ready) begin
				if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = word_backlog.pop_front();
					in_valid <= 1'b1;
					kind     <= next_word.kind;
					sample   <= next_word.sample;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure, each result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					note_mismatch("unexpected word, write_index", '0, write_index);
				end else begin
					front_result = expected_results.pop_front();
					results_checked++;
					if (block_end) block_ends_seen++;
					if (trigger) triggers_seen++;
					if (write_index !== front_result.write_index)
						note_mismatch("write_index", front_result.write_index, write_index);
					if (block_end !== front_result.block_end)
						note_mismatch("block_end", IDX_W'(front_result.block_end),
							IDX_W'(block_end));
					if (trigger !== front_result.trigger)
						note_mismatch("trigger", IDX_W'(front_result.trigger),
							IDX_W'(trigger));
					if (pending !== front_result.pending)
						note_mismatch("pending", IDX_W'(front_result.pending),
							IDX_W'(pending));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one register write, shadow updated when the write is taken
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BLOCK_LENGTH:     shadow_blen   = val[BLEN_W-1:0];
			REG_ENERGY_THRESHOLD: shadow_thresh = val[ENERGY_W-1:0];
			REG_HOLDOFF_BLOCKS:   shadow_hold   = val[HOLD_W-1:0];
			REG_CAPTURE_LENGTH:   shadow_caplen = val[CAPLEN_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic load_setting(input logic [BLEN_W-1:0] blen, input energy_t thresh,
			input logic [HOLD_W-1:0] hold, input logic [CAPLEN_W-1:0] caplen);
		write_reg(REG_BLOCK_LENGTH, CFG_DATA_W'(blen));
		write_reg(REG_ENERGY_THRESHOLD, thresh);
		write_reg(REG_HOLDOFF_BLOCKS, CFG_DATA_W'(hold));
		write_reg(REG_CAPTURE_LENGTH, CFG_DATA_W'(caplen));
	endtask

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
		word_backlog.push_back('{kind: KIND_AUDIO, sample: s});
	endtask

	// analysis finished, the sample bits are noise the block ignores
	task automatic push_done();
		word_backlog.push_back('{kind: KIND_DONE, sample: SAMPLE_W'($urandom)});
	endtask

	// runs of loud or quiet samples so blocks land on both sides of the threshold
	task automatic push_audio_stream(input int n_samples, input int done_pct);
		int                         run_left;
		logic                       loud;
		logic signed [SAMPLE_W-1:0] s;
		run_left = 0;
		loud     = 1'b0;
		for (int i = 0; i < n_samples; i++) begin
			if (run_left == 0) begin
				loud     = 1'($urandom_range(1));
				run_left = $urandom_range(1, 16);
			end
			run_left--;
			if ($urandom_range(99) < done_pct) push_done();
			if (loud) begin
				s = SAMPLE_W'($urandom);
			end else begin
				s = SAMPLE_W'($urandom_range(31));
				s = s - 24'sd16;
			end
			push_sample(s);
		end
	endtask

	// block is idle once every word is in and every result is out
	task automatic wait_drained();
		while (word_backlog.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		// then let the block idle before the next register write
		repeat (4) @(posedge clk);
	endtask

	initial begin
		// register defaults and cleared state after reset
		shadow_blen    = BLOCK_LENGTH_RST;
		shadow_thresh  = ENERGY_THRESHOLD_RST;
		shadow_hold    = HOLDOFF_BLOCKS_RST;
		shadow_caplen  = CAPTURE_LENGTH_RST;
		cap_pos        = '0;
		blk_cnt        = '0;
		energy_acc     = '0;
		blocks_elapsed = '0;
		pend_flag      = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// phase one: slow receiver
		send_idle_pct = 27;
		recv_idle_pct = 87;

		// reset defaults: sample extremes and an early analysis-done
		push_sample(24'sh7FFFFF);
		push_sample(24'sh800000);
		push_sample(24'sh000000);
		push_sample(24'shFFFFFF);
		push_done();
		wait_drained();

		// block of four, four samples already counted so the first ends a block
		load_setting(9'd4, energy_t'(4) << 40, 16'd0, 15'd5);
		write_reg(REG_UNUSED, {CFG_DATA_W{1'b1}});
		push_sample(24'sh000001);
		// loud block while analysis is pending, no new trigger
		push_sample(24'sh7FFFFF);
		push_sample(24'sh800000);
		push_sample(24'sh7FFFFF);
		push_sample(24'sh800000);
		push_done();
		// loud block with nothing pending triggers again
		push_sample(24'sh7FFFFF);
		push_sample(24'sh7FFFFF);
		push_sample(24'sh7FFFFF);
		push_sample(24'sh800000);
		// quiet blocks stay below the threshold
		push_sample(24'sh000001);
		push_sample(24'shFFFFFF);
		push_sample(24'sh000000);
		push_sample(24'sh000002);
		push_done();
		push_sample(24'sh000003);
		push_sample(24'sh000003);
		push_sample(24'sh000003);
		push_sample(24'sh000003);
		wait_drained();

		load_setting(9'd8, energy_t'(8) << 40, 16'd2, 15'd37);
		push_audio_stream(40, 8);
		wait_drained();

		// zero block and capture lengths act as one
		load_setting(9'd0, energy_t'(1) << 40, 16'd0, 15'd0);
		push_audio_stream(30, 10);
		wait_drained();

		// phase two: slow sender
		send_idle_pct = 87;
		recv_idle_pct = 27;

		// oversized lengths clamp to 256 samples and the full buffer, zero threshold
		load_setting({BLEN_W{1'b1}}, '0, 16'd1, {CAPLEN_W{1'b1}});
		push_audio_stream(260, 3);
		wait_drained();

		// unreachable threshold and the longest holdoff
		load_setting(BLEN_MAX, {ENERGY_W{1'b1}}, HOLD_MAX, 15'd16384);
		push_audio_stream(30, 5);
		wait_drained();

		// phase three: no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// shortened block and buffer: position and count lie beyond the new lengths
		load_setting(9'd3, energy_t'(3) << 40, 16'd0, 15'd7);
		push_audio_stream(30, 8);
		wait_drained();

		load_setting(9'd2, energy_t'(2) << 40, 16'd5, 15'd100);
		push_audio_stream(40, 6);
		wait_drained();

		$display("stimulus: %0d words over eight register settings and three idle mixes",
			words_sent);
		$display("results checked %0d, block ends %0d, triggers %0d, mismatches %0d",
			results_checked, block_ends_seen, triggers_seen, mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#(20 * 400000);
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
